/* src/sb2d_pkg.sv */
// Shared constants, control struct and sizing function for the decimal text converter.
`default_nettype none

package sb2d_pkg;

   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Decimal digits needed for magnitudes up to 2^(w-1): floor((w-1)*log10(2)) + 1.
   function automatic int digits_for(input int w);
      return ((w - 1) * 30103) / 100000 + 1;
   endfunction

   // Commands from the sequencer to the shift-and-add-3 datapath.
   typedef struct packed {
      logic load;   // load the binary magnitude, clear the BCD register
      logic conv;   // one shift-and-add-3 step: move one binary bit into the BCD digits
      logic shift;  // drop the top BCD digit, move the others up by one digit
   } ctrl_type;

endpackage

`default_nettype wire

/* src/sb2d_dabble.sv */
// Bit-serial binary to BCD datapath with digit-wise output shifting.
`default_nettype none

module sb2d_dabble
   import sb2d_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire ctrl_type               ctrl,
   input  wire logic [VALUE_WIDTH-1:0] load_mag,
   output logic [3:0]                  top_digit
);

   localparam int DIGITS   = digits_for(VALUE_WIDTH);
   localparam int BCD_BITS = DIGITS * 4;

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]    adj;

   // Add 3 to every digit of 5 or more before the shift; digits are independent.
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = load_mag;
         bcd_in = '0;
      end else if (ctrl.conv) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adj[BCD_BITS-2:0], bin_ff[VALUE_WIDTH-1]};
      end else if (ctrl.shift) begin
         // Move every digit up by one; a single-digit register simply clears.
         bcd_in = bcd_ff << 4;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];

endmodule

`default_nettype wire

/* src/signed_binary_to_decimal_ascii.sv */
// Top level: signed integer to decimal ASCII text, one character per transaction.
`default_nettype none

// Converts one signed VALUE_WIDTH-bit integer per request transaction into its
// decimal text, sent as one ASCII character per response transaction, most
// significant first. A negative value starts with '-', leading zeros are
// dropped, zero gives a single '0', and rsp_last marks the final character.
// The most negative value converts correctly ("-2147483648" at 32 bits).
// One value is handled at a time: req_stall stays high from acceptance until
// the last character has been placed in the output register. The magnitude is
// turned into BCD by a shift-and-add-3 loop that takes one binary bit per
// cycle. Leading zero digits are then dropped one per cycle, and each
// character waits in the output register until the receiver takes it.
// The output register lets the next value be accepted while the last
// character still waits for the receiver.

module signed_binary_to_decimal_ascii
   import sb2d_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_ascii_char,
   output logic                               rsp_last
);

   localparam int DIGITS    = digits_for(VALUE_WIDTH);
   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_CNT_W = $clog2(DIGITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   ctrl_type               ctrl;
   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] mag;
   logic [3:0]             top_digit;
   logic                   req_accept;
   logic                   out_free;

   // Magnitude as an unsigned quantity, so the most negative value does not overflow.
   assign raw = req_value;
   assign mag = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // Output register can take a character when empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               ctrl.load  = 1'b1;
               neg_in     = raw[VALUE_WIDTH-1];
               bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH);
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // Move one magnitude bit into the BCD digits per cycle.
            ctrl.conv  = 1'b1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               dig_cnt_in = DIG_CNT_W'(DIGITS);
               state_in   = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Drop leading zero digits, but always keep the units digit.
            if ((top_digit == 4'd0) && (dig_cnt_ff != DIG_CNT_W'(1))) begin
               ctrl.shift = 1'b1;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + {4'd0, top_digit};
               rsp_last_in  = (dig_cnt_ff == DIG_CNT_W'(1));
               ctrl.shift   = 1'b1;
               dig_cnt_in   = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   sb2d_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dabble (
      .clock     (clock),
      .ctrl      (ctrl),
      .load_mag  (mag),
      .top_digit (top_digit)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

/* tb/tb_signed_binary_to_decimal_ascii.sv */
// Self-checking testbench for the signed binary to decimal ASCII text converter.
module tb_signed_binary_to_decimal_ascii;
   import sb2d_pkg::*;

   localparam int VW          = VALUE_WIDTH_DEF;
   localparam int RANDOM_JOBS = 390;
   localparam int QUIET_TAIL  = 60;       // final jobs sent with no idling on either side
   localparam int CYCLE_LIMIT = 400000;   // watchdog limit, far above what all 412 jobs need
   localparam int SETTLE      = 80;       // extra cycles run after the last expected character

   // One value waiting to be sent, with its pacing controls.
   typedef struct {
      logic signed [VW-1:0] value;
      bit                   drain_first;  // hold off until all text of earlier values is out
      bit                   gaps_ok;      // idling allowed while this value is in flight
   } conversion_job_type;

   // One expected output character.
   typedef struct {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [VW-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_ascii_char;
   logic                 rsp_last;

   conversion_job_type jobs_pending[$];
   text_char_type      text_due[$];

   logic        req_fired = 1'b0;   // request transaction taken at the last rising edge
   logic        gaps_on = 1'b1;     // idling enabled for the value now in flight
   bit          send_rolled = 1'b0; // idle burst already decided for the next job
   int          send_gap = 0;
   int          stall_left = 0;
   int unsigned cycle_count = 0;
   int          error_count = 0;
   int          values_taken = 0;
   int          negatives_taken = 0;
   int          chars_checked = 0;
   int          longest_text = 0;

   signed_binary_to_decimal_ascii #(
      .VALUE_WIDTH(VW)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at cycle %0d: %s", cycle_count, what);
   endtask

   // Build the expected text of one value: optional '-', then the digits of
   // the magnitude, most significant first. The magnitude is taken as an
   // unsigned VW-bit quantity so the most negative value does not overflow.
   task automatic expand_decimal(input logic signed [VW-1:0] v);
      logic [VW-1:0] mag;
      logic [3:0]    digit [0:19];
      int            n;
      int            i;
      text_char_type c;
      mag = v[VW-1] ? (~v + 1'b1) : v;
      n = 0;
      if (mag == 0) begin
         digit[0] = 4'd0;
         n = 1;
      end
      while (mag != 0) begin
         digit[n] = 4'(mag % 10);
         mag = mag / 10;
         n++;
      end
      if (v[VW-1]) begin
         c.ch   = ASCII_MINUS;
         c.last = 1'b0;
         text_due.push_back(c);
         negatives_taken++;
      end
      for (i = n - 1; i >= 0; i--) begin
         c.ch   = ASCII_ZERO + digit[i];
         c.last = (i == 0);
         text_due.push_back(c);
      end
      if (n + v[VW-1] > longest_text) begin
         longest_text = n + v[VW-1];
      end
      values_taken++;
   endtask

   // Random value: half the time a random digit count with random sign, else fully
   // random words, tiny values and values at the range ends.
   function automatic logic signed [VW-1:0] random_value();
      longint lo;
      longint hi;
      longint mag;
      int     d;
      int     k;
      logic signed [VW-1:0] r;
      case ($urandom_range(0, 9))
         0, 1, 2: r = $urandom;
         3: begin
            r = $urandom_range(0, 20);
            if ($urandom_range(0, 1)) begin
               r = -r;
            end
         end
         4: begin
            k = $urandom_range(0, 5);
            case (k)
               0: r = {1'b0, {(VW-1){1'b1}}};
               1: r = {1'b1, {(VW-1){1'b0}}};
               2: r = {1'b1, {(VW-2){1'b0}}, 1'b1};
               3: r = {1'b0, {(VW-2){1'b1}}, 1'b0};
               4: r = '1;
               default: r = '0;
            endcase
         end
         default: begin
            d  = $urandom_range(1, 10);
            lo = 1;
            for (k = 1; k < d; k++) begin
               lo = lo * 10;
            end
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647) begin
               hi = 64'sd2147483647;
            end
            mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
            r = VW'(mag);
            if ($urandom_range(0, 1)) begin
               r = -r;
            end
         end
      endcase
      return r;
   endfunction

   // Request driver: change inputs at the falling edge only. Hold the payload
   // until the transaction is taken, then idle for a burst or present the next
   // queued value.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // hold: not yet taken
      end else if (send_gap > 0) begin
         send_gap  <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (jobs_pending.size() == 0 ||
                   (jobs_pending[0].drain_first && text_due.size() != 0)) begin
         req_valid <= 1'b0;
      end else if (!send_rolled && jobs_pending[0].gaps_ok && $urandom_range(0, 3) == 0) begin
         // start an idle burst, this cycle included; send_gap counts the rest
         send_rolled <= 1'b1;
         send_gap    <= $urandom_range(0, 13);
         req_valid   <= 1'b0;
      end else begin
         req_value   <= jobs_pending[0].value;
         gaps_on     <= jobs_pending[0].gaps_ok;
         req_valid   <= 1'b1;
         send_rolled <= 1'b0;
         void'(jobs_pending.pop_front());
      end
   end

   // Response-side backpressure: stall bursts, started independent of
   // rsp_valid so they land on every phase of the conversion.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check each response transaction against the oldest expected
   // character, then predict the text of any request taken at this edge.
   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            chars_checked++;
            if (text_due.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         rsp_ascii_char, rsp_last));
            end else begin
               if (rsp_ascii_char !== text_due[0].ch) begin
                  report_mismatch($sformatf("ascii_char 0x%02h, want 0x%02h",
                                            rsp_ascii_char, text_due[0].ch));
               end
               if (rsp_last !== text_due[0].last) begin
                  report_mismatch($sformatf("last %0b, want %0b (char 0x%02h)",
                                            rsp_last, text_due[0].last, text_due[0].ch));
               end
               void'(text_due.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            expand_decimal(req_value);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout: %0d characters still expected", text_due.size());
         $display("signed_binary_to_decimal_ascii: mismatch");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      logic signed [VW-1:0] directed [$];
      conversion_job_type   job;
      int                   i;
      int                   total;

      // Directed: zero, single digits, digit-count boundaries, both range ends
      // including the most negative value, and alternating bit patterns.
      directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                   32'sd99, 32'sd100, -32'sd1000, 32'sd123456789, -32'sd987654321,
                   32'sd999999999, 32'sd1000000000, -32'sd1000000000,
                   32'sd2147483647, -32'sd2147483647, {1'b1, {(VW-1){1'b0}}},
                   32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFE, -32'sd5};
      total = directed.size() + RANDOM_JOBS;
      for (i = 0; i < total; i++) begin
         job.value       = (i < directed.size()) ? directed[i] : random_value();
         // drain the block completely a few times during the run
         job.drain_first = (i == 12) || (i == 150) || (i == 300);
         // every third block of 40 jobs runs with no idling; the tail is quiet too
         job.gaps_ok     = (i < total - QUIET_TAIL) && ((i / 40) % 3 != 2);
         jobs_pending.push_back(job);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every job to be taken and every character to come back.
      while (jobs_pending.size() != 0 || req_valid || text_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);

      $display("converted %0d values (%0d negative), %0d characters checked, longest text %0d",
               values_taken, negatives_taken, chars_checked, longest_text);
      $display("idle and stall bursts on both sides, three full drains, quiet tail of %0d",
               QUIET_TAIL);
      if (error_count == 0) begin
         $display("signed_binary_to_decimal_ascii: match");
      end else begin
         $display("signed_binary_to_decimal_ascii: mismatch");
      end
      $finish;
   end

endmodule
